FILE: rtl/tce_pkg.sv
// shared types and constants of the text console character engine
package tce_pkg;

	localparam int TCE_COLUMNS  = 80;
	localparam int TCE_ROWS     = 25;
	localparam int TCE_TAB_STEP = 8;

	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]  SPACE_CHAR = 8'h20;
	localparam logic [7:0]  ATTR_RESET = 8'h0F;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef struct packed {
		logic        kind;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_position;
	} result_t;

endpackage

FILE: rtl/tce_ram.sv
// generic single write port ram with registered read
module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/text_console_character_engine.sv
// text console character engine: screen store, cursor and microcoded control
//
// Usage: a transaction is accepted on a rising edge with start high and busy low.
// item.kind selects a character (0) or a cell read (1). Every transaction gives
// exactly one result on the result port, marked by done for one cycle; the
// receiver cannot hold it off. The result shows the cell read (0 for a
// character or an out-of-range index) and the cursor after the transaction.
// Flow: cell reads, cursor control and ordinary characters go straight to the
// report step; a character in the last column is followed by a newline; a
// newline on the bottom row scrolls, reading and then writing one cell at a time
// up one row and filling the last row with spaces; form feed sweeps every cell.
// The next start is taken in the cycle done is shown. Rate is set by the single
// screen ram port pair.
// Reset: the cursor homes, the attribute returns to 0x0f and a clearing pass
// writes every cell blank with busy high.
// cfg_data writes the attribute whenever cfg_valid is high; ready is always high.
module text_console_character_engine
	import tce_pkg::*;
#(
	parameter int COLUMNS  = tce_pkg::TCE_COLUMNS,
	parameter int ROWS     = tce_pkg::TCE_ROWS,
	parameter int TAB_STEP = tce_pkg::TCE_TAB_STEP
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tce_pkg::item_t   item,
	output logic             done,
	output tce_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);
	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int TAB_W  = $clog2(COLUMNS + TAB_STEP + 1);
	localparam int TAB_N  = (COLUMNS - 1) / TAB_STEP;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

	// program steps
	localparam logic [3:0] S_CLR0   = 4'd0;
	localparam logic [3:0] S_CLR1   = 4'd1;
	localparam logic [3:0] S_CLR2   = 4'd2;
	localparam logic [3:0] S_IDLE   = 4'd3;
	localparam logic [3:0] S_READ   = 4'd4;
	localparam logic [3:0] S_MOVE   = 4'd5;
	localparam logic [3:0] S_WRITE  = 4'd6;
	localparam logic [3:0] S_NL     = 4'd7;
	localparam logic [3:0] S_SCR0   = 4'd8;
	localparam logic [3:0] S_SCR1   = 4'd9;
	localparam logic [3:0] S_SCR2   = 4'd10;
	localparam logic [3:0] S_FILL0  = 4'd11;
	localparam logic [3:0] S_FILL1  = 4'd12;
	localparam logic [3:0] S_REPORT = 4'd13;

	// datapath actions
	localparam logic [3:0] A_NOP      = 4'd0;
	localparam logic [3:0] A_SET_CLR  = 4'd1;
	localparam logic [3:0] A_WR_BLANK = 4'd2;
	localparam logic [3:0] A_HOME     = 4'd3;
	localparam logic [3:0] A_ACCEPT   = 4'd4;
	localparam logic [3:0] A_READ     = 4'd5;
	localparam logic [3:0] A_MOVE     = 4'd6;
	localparam logic [3:0] A_WR_CHAR  = 4'd7;
	localparam logic [3:0] A_NEWLINE  = 4'd8;
	localparam logic [3:0] A_SET_SCR  = 4'd9;
	localparam logic [3:0] A_RD_SRC   = 4'd10;
	localparam logic [3:0] A_COPY     = 4'd11;
	localparam logic [3:0] A_SET_FILL = 4'd12;
	localparam logic [3:0] A_WR_SPACE = 4'd13;
	localparam logic [3:0] A_REPORT   = 4'd14;

	// sequencing conditions
	localparam logic [2:0] C_NEXT    = 3'd0;
	localparam logic [2:0] C_GOTO    = 3'd1;
	localparam logic [2:0] C_LOOP    = 3'd2;
	localparam logic [2:0] C_PEND    = 3'd3;
	localparam logic [2:0] C_NOT_EOL = 3'd4;
	localparam logic [2:0] C_NOT_BOT = 3'd5;
	localparam logic [2:0] C_DISP    = 3'd6;

	typedef struct packed {
		logic [3:0] act;
		logic [2:0] cond;
		logic [3:0] target;
	} ucode_t;

	function automatic ucode_t ucode(input logic [3:0] step);
		ucode_t w;
		unique case (step)
			S_CLR0:   w = '{A_SET_CLR,  C_NEXT,    S_CLR1};
			S_CLR1:   w = '{A_WR_BLANK, C_LOOP,    S_CLR1};
			S_CLR2:   w = '{A_HOME,     C_PEND,    S_REPORT};
			S_IDLE:   w = '{A_ACCEPT,   C_DISP,    S_IDLE};
			S_READ:   w = '{A_READ,     C_GOTO,    S_REPORT};
			S_MOVE:   w = '{A_MOVE,     C_GOTO,    S_REPORT};
			S_WRITE:  w = '{A_WR_CHAR,  C_NOT_EOL, S_REPORT};
			S_NL:     w = '{A_NEWLINE,  C_NOT_BOT, S_REPORT};
			S_SCR0:   w = '{A_SET_SCR,  C_NEXT,    S_SCR1};
			S_SCR1:   w = '{A_RD_SRC,   C_NEXT,    S_SCR2};
			S_SCR2:   w = '{A_COPY,     C_LOOP,    S_SCR1};
			S_FILL0:  w = '{A_SET_FILL, C_NEXT,    S_FILL1};
			S_FILL1:  w = '{A_WR_SPACE, C_LOOP,    S_FILL1};
			S_REPORT: w = '{A_REPORT,   C_GOTO,    S_IDLE};
			default:  w = '{A_NOP,      C_GOTO,    S_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [3:0] dispatch(input item_t it);
		logic [3:0] s;
		if (it.kind == KIND_READ) begin
			s = S_READ;
		end else begin
			case (it.char_code) inside
				CH_BS, CH_TAB, CH_CR: s = S_MOVE;
				CH_LF:                s = S_NL;
				CH_FF:                s = S_CLR0;
				default:              s = S_WRITE;
			endcase
		end
		return s;
	endfunction

	logic [3:0]        pc_q;
	logic [3:0]        pc_next;
	ucode_t            uc;
	logic              pending_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [7:0]        attr_q;
	logic              kind_q;
	logic [7:0]        char_q;
	logic [10:0]       idx_q;
	logic              in_range_q;
	logic              done_q;
	result_t           res_q;

	logic [ADDR_W-1:0] cur_addr;
	logic [TAB_W-1:0]  tab_stop;
	logic [COL_W-1:0]  tab_col;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	assign uc        = ucode(pc_q);
	assign busy      = (pc_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;
	assign cur_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

	always_comb begin
		tab_stop = TAB_W'(TAB_STEP);
		for (int k = 1; k <= TAB_N; k++) begin
			if (col_q >= COL_W'(k * TAB_STEP)) begin
				tab_stop = TAB_W'((k + 1) * TAB_STEP);
			end
		end
		if (tab_stop > TAB_W'(COLUMNS - 1)) begin
			tab_col = COL_LAST;
		end else begin
			tab_col = COL_W'(tab_stop);
		end
	end

	always_comb begin
		unique case (uc.cond)
			C_NEXT:    pc_next = pc_q + 4'd1;
			C_GOTO:    pc_next = uc.target;
			C_LOOP:    pc_next = (ptr_q != LAST_CELL) ? uc.target : pc_q + 4'd1;
			C_PEND:    pc_next = pending_q ? uc.target : pc_q + 4'd1;
			C_NOT_EOL: pc_next = (col_q != COL_LAST) ? uc.target : pc_q + 4'd1;
			C_NOT_BOT: pc_next = (row_q != ROW_LAST) ? uc.target : pc_q + 4'd1;
			C_DISP:    pc_next = start ? dispatch(item) : pc_q;
			default:   pc_next = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		case (uc.act)
			A_WR_BLANK: begin
				ram_we    = 1'b1;
				ram_wdata = BLANK_CELL;
			end
			A_WR_CHAR: begin
				ram_we    = 1'b1;
				ram_waddr = cur_addr;
				ram_wdata = {attr_q, char_q};
			end
			A_COPY: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q - ADDR_W'(COLUMNS);
			end
			A_WR_SPACE: begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, SPACE_CHAR};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr = (uc.act == A_READ) ? ADDR_W'(idx_q) : ptr_q;
	end

	tce_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.act == A_ACCEPT && start) begin
			kind_q     <= item.kind;
			char_q     <= item.char_code;
			idx_q      <= item.cell_index;
			in_range_q <= (32'(item.cell_index) < 32'(CELLS));
		end
		if (uc.act == A_REPORT) begin
			res_q.cell_data       <= (kind_q == KIND_READ && in_range_q) ? ram_rdata : 16'd0;
			res_q.cursor_row      <= 5'(row_q);
			res_q.cursor_col      <= 7'(col_q);
			res_q.cursor_position <= 11'(cur_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= S_CLR0;
			pending_q <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
			ptr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			pc_q   <= pc_next;
			done_q <= 1'b0;
			case (uc.act)
				A_SET_CLR: ptr_q <= '0;
				A_WR_BLANK, A_COPY, A_WR_SPACE: ptr_q <= ptr_q + ADDR_W'(1);
				A_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				A_ACCEPT: begin
					if (start) begin
						pending_q <= 1'b1;
					end
				end
				A_MOVE: begin
					case (char_q)
						CH_BS: begin
							if (col_q != '0) begin
								col_q <= col_q - COL_W'(1);
							end
						end
						CH_TAB:  col_q <= tab_col;
						CH_CR:   col_q <= '0;
						default: col_q <= col_q;
					endcase
				end
				A_WR_CHAR: begin
					if (col_q != COL_LAST) begin
						col_q <= col_q + COL_W'(1);
					end
				end
				A_NEWLINE: begin
					col_q <= '0;
					if (row_q != ROW_LAST) begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				A_SET_SCR:  ptr_q <= ADDR_W'(COLUMNS);
				A_SET_FILL: ptr_q <= ADDR_W'(CELLS - COLUMNS);
				A_REPORT: begin
					done_q    <= 1'b1;
					pending_q <= 1'b0;
				end
				default: ptr_q <= ptr_q;
			endcase
		end
	end

endmodule

FILE: rtl/tce_checker.sv
// port level checks of the text console character engine and their binding
module tce_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// one result per transaction, never in consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held for two cycles");

	// result comes out as the engine returns to idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// result follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result without preceding work");

	// an accepted transaction keeps the engine busy next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("transaction accepted but engine not busy");

endmodule

bind text_console_character_engine tce_checker u_tce_checker (.*);
